>>> hw/rtl/csm_pkg.sv
// Shared types, constants and helpers for the case folding substring matcher.
package csm_pkg;

  localparam int PATTERN_MAX = 128;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] UPPER_LO    = 8'd65;
  localparam logic [7:0] UPPER_HI    = 8'd90;
  localparam logic [7:0] FOLD_OFFSET = 8'd32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic found;
    logic pattern_overflow;
  } out_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      r = c + FOLD_OFFSET;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/csm_front.sv
// Front end: takes input transfers, folds pattern bytes and queues commands.
module csm_front import csm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic cmd_valid,
  input  logic cmd_stall,
  output cmd_t cmd
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  cmd_t              classified;

  assign in_stall  = (count == QCNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && !cmd_stall;
  assign cmd       = q[rd_ptr];

  // Fold pattern letters here so the back end compares raw text bytes.
  always_comb begin
    classified.op   = op_t'(in_item.operation);
    classified.data = in_item.data_byte;
    if (classified.op == OP_APPEND) begin
      classified.data = fold_upper(in_item.data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classified;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == QCNT_W'($past(count) - 1'b1))
    else $error("queue count did not drop on drain");

  a_pass_empty: assert property (@(posedge clk) disable iff (rst)
    push && count == '0 |=> cmd_valid && cmd == $past(classified))
    else $error("queued command not at head");
`endif

endmodule

>>> hw/rtl/csm_back.sv
// Back end: pattern store, parallel partial-match vector and result register.
module csm_back import csm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic [7:0]             store [PATTERN_MAX];
  logic [LEN_W-1:0]       len;
  logic [PATTERN_MAX-1:0] pm;
  logic [PATTERN_MAX-1:0] pm_text;
  logic                   found_flag;
  logic                   overflow;
  logic                   pop;
  logic                   full;
  logic                   hit;
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       last_idx;

  // Hold end-of-text while the result register is still occupied.
  assign cmd_stall = (cmd.op == OP_END) && out_valid && out_stall;
  assign pop       = cmd_valid && !cmd_stall;
  assign full      = (len >= LEN_W'(PATTERN_MAX));
  assign wr_idx    = len[IDX_W-1:0];
  assign last_idx  = IDX_W'(len - 1'b1);

  // Positions at or above the length may go stale; nothing reads them and
  // every pattern change clears the vector.
  always_comb begin
    pm_text[0] = (store[0] == cmd.data);
    for (int k = 1; k < PATTERN_MAX; k++) begin
      pm_text[k] = pm[k-1] && (store[k] == cmd.data);
    end
  end

  assign hit = (len != '0) && pm_text[last_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      pm         <= '0;
      found_flag <= 1'b0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(pop && cmd.op == OP_END)) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        case (cmd.op)
          OP_CLEAR: begin
            len        <= '0;
            overflow   <= 1'b0;
            pm         <= '0;
            found_flag <= 1'b0;
          end
          OP_APPEND: begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              len <= len + 1'b1;
            end
            pm         <= '0;
            found_flag <= 1'b0;
          end
          OP_TEXT: begin
            pm <= pm_text;
            if (hit) begin
              found_flag <= 1'b1;
            end
          end
          default: begin
            out_valid  <= 1'b1;
            pm         <= '0;
            found_flag <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.op == OP_APPEND && !full) begin
      store[wr_idx] <= cmd.data;
    end
    if (pop && cmd.op == OP_END) begin
      out_item.found            <= (len == '0) || found_flag;
      out_item.pattern_overflow <= overflow;
    end
  end

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    pop && cmd.op == OP_CLEAR |=> len == '0 && !overflow && pm == '0 && !found_flag)
    else $error("clear left state behind");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    pop && cmd.op == OP_APPEND && full |=> overflow && len == $past(len))
    else $error("dropped byte not flagged");

  a_end: assert property (@(posedge clk) disable iff (rst)
    pop && cmd.op == OP_END |=> out_valid && pm == '0 && !found_flag)
    else $error("end of text did not post a result");
`endif

endmodule

>>> hw/rtl/case_folding_substring_matcher.sv
// Top level of the case folding substring matcher.
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries commands: clear
//   pattern, append pattern byte, text byte, end of text. A transfer happens
//   on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall / out_item) carries one result per
//   end of text: found and pattern_overflow.
//   Uppercase pattern letters are folded to lowercase; text is compared raw.
//   An empty pattern always reports found.
// Throughput: one command per cycle unless an end of text is held. Every
//   pattern position compares in parallel, so text bytes stream back to back.
// Result path: an end of text passes the two-entry command queue, then the
//   result register, which raises out_valid.
// Stall: while a result waits on out_stall, the next end of text holds at
//   the head of the queue and blocks the commands behind it; commands ahead
//   of it keep executing, and in_stall rises only when the queue is full.
// Reset: rst (synchronous, active high) empties the queue, the pattern
//   length, the match vector and the flags; pattern bytes need no reset.
module case_folding_substring_matcher import csm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_item
);

  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;

  csm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

  csm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> tb/csm_search_checker.sv
// Transfer monitor, search predictor and result scoreboard for the substring matcher.
module csm_search_checker import csm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_item,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_item,
  output int   errors,
  output int   pending,
  output int   verdicts,
  output int   hits,
  output int   overflows
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  logic [7:0]             pat_bytes [PATTERN_MAX];
  int unsigned            pat_len = 0;
  logic [PATTERN_MAX-1:0] run_bits = '0;
  logic                   seen = 1'b0;
  logic                   dropped = 1'b0;
  out_t                   expected_verdicts [$];
  out_t                   want;

  initial begin
    errors    = 0;
    pending   = 0;
    verdicts  = 0;
    hits      = 0;
    overflows = 0;
  end

  // Uppercase letters have bit 5 clear; setting it gives the lowercase letter.
  function automatic logic [7:0] lowered(input logic [7:0] c);
    if (c >= UPPER_LO && c <= UPPER_HI) begin
      return {c[7:6], 1'b1, c[4:0]};
    end
    return c;
  endfunction

  task automatic forget_matches();
    run_bits = '0;
    seen     = 1'b0;
  endtask

  task automatic advance_search(input in_t cmd);
    logic [PATTERN_MAX-1:0] eq;
    out_t                   v;
    case (op_t'(cmd.operation))
      OP_CLEAR: begin
        pat_len = 0;
        dropped = 1'b0;
        forget_matches();
      end
      OP_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = cmd.data_byte;
          pat_len++;
        end else begin
          dropped = 1'b1;
        end
        forget_matches();
      end
      OP_TEXT: begin
        for (int p = 0; p < PATTERN_MAX; p++) begin
          eq[p] = (p < pat_len) && (lowered(pat_bytes[p]) == cmd.data_byte);
        end
        // Every position extends its predecessor; position 0 always may start.
        run_bits = {run_bits[PATTERN_MAX-2:0], 1'b1} & eq;
        if (pat_len > 0 && run_bits[pat_len-1]) begin
          seen = 1'b1;
        end
      end
      default: begin
        v.found            = (pat_len == 0) ? 1'b1 : seen;
        v.pattern_overflow = dropped;
        expected_verdicts.push_back(v);
        forget_matches();
      end
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic exp_bit, input logic got_bit);
    if (errors < MAX_REPORTS) begin
      $display("%0t: mismatch on %s: expected %b, got %b", $realtime, what, exp_bit, got_bit);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_len = 0;
      dropped = 1'b0;
      forget_matches();
      expected_verdicts.delete();
    end else begin
      if (in_valid && !in_stall) begin
        advance_search(in_item);
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("out_valid with no result pending", 1'b0, 1'b1);
        end else begin
          want = expected_verdicts.pop_front();
          verdicts++;
          if (out_item.found) hits++;
          if (out_item.pattern_overflow) overflows++;
          if (out_item.found !== want.found) begin
            flag_mismatch("found", want.found, out_item.found);
          end
          if (out_item.pattern_overflow !== want.pattern_overflow) begin
            flag_mismatch("pattern_overflow", want.pattern_overflow, out_item.pattern_overflow);
          end
        end
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

>>> tb/case_folding_substring_matcher_test.sv
// Stimulus, flow control and verdict for the case folding substring matcher.
module case_folding_substring_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csm_pkg::*;

  localparam int ITEM_TARGET = 1350;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_item;

  int errors, pending, verdicts, hits, overflows;

  int           sent = 0;
  int           burst_left = 0;
  bit           idle_sender = 1'b0;
  int           cycle_count = 0;
  int           stall_run = 0;
  stall_style_t stall_style = STALL_NONE;
  logic [7:0]   pat_copy [$];

  case_folding_substring_matcher i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  csm_search_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending),
    .verdicts  (verdicts),
    .hits      (hits),
    .overflows (overflows)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("case_folding_substring_matcher_test: errors");
      $finish;
    end
  end

  // Receiver back-pressure: switch style every so often, including runs with no stall.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_run   = $urandom_range(16, 160);
    end
    stall_run--;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
      default:     out_stall <= ((stall_run % 8) < 3);
    endcase
  end

  // Present one command and hold it until the transfer; return at the next falling edge.
  task automatic send(input op_t op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = idle_sender ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= {op, b};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
    // Track the stored pattern, folded, to build matching text.
    if (op == OP_CLEAR) begin
      pat_copy.delete();
    end else if (op == OP_APPEND && pat_copy.size() < PATTERN_MAX) begin
      pat_copy.push_back(fold_upper(b));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pattern_byte();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1, 2, 3: return "A" + 8'($urandom_range(0, 2));
      default: return "a" + 8'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return "A" + 8'($urandom_range(0, 2));
      default: return "a" + 8'($urandom_range(0, 2));
    endcase
  endfunction

  // Build a pattern, then stream a few texts, some holding the pattern or a near miss.
  task automatic search_episode(input bit long_pattern);
    int plen, tlen, spot, bad;
    bit splice;
    if ($urandom_range(0, 7) != 0) send(OP_CLEAR, 8'($urandom_range(0, 255)));
    if (long_pattern) begin
      plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 6);
    end else begin
      plen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
    end
    repeat (plen) send(OP_APPEND, pattern_byte());
    repeat ($urandom_range(1, 4)) begin
      tlen   = $urandom_range(0, 12);
      spot   = $urandom_range(0, tlen);
      splice = $urandom_range(0, 1);
      bad    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, pat_copy.size()) : -1;
      for (int i = 0; i <= tlen; i++) begin
        if (splice && i == spot) begin
          foreach (pat_copy[j]) send(OP_TEXT, (j == bad) ? pat_copy[j] ^ 8'h01 : pat_copy[j]);
        end
        if (i < tlen) send(OP_TEXT, text_byte());
      end
      send(OP_END, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int episodes, longs, pick;
    episodes = 0;
    longs    = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Empty pattern matches with and without text.
    send(OP_END, 8'h00);
    send(OP_TEXT, 8'h00); send(OP_TEXT, 8'hFF); send(OP_END, 8'hFF);
    // Fold edges: A and Z fold, the neighbors @ and [ do not.
    send(OP_APPEND, "A"); send(OP_APPEND, "Z"); send(OP_APPEND, "@"); send(OP_APPEND, "[");
    send(OP_END, 8'h00);
    // Uppercase text is not folded, so it must miss.
    send(OP_TEXT, "A"); send(OP_TEXT, "Z"); send(OP_TEXT, "@"); send(OP_TEXT, "[");
    send(OP_END, 8'h00);
    send(OP_TEXT, "a"); send(OP_TEXT, "z"); send(OP_TEXT, "@"); send(OP_TEXT, "[");
    send(OP_END, 8'h00);
    // Byte extremes in pattern and text.
    send(OP_CLEAR, 8'hFF);
    send(OP_APPEND, 8'hFF); send(OP_APPEND, 8'h00);
    send(OP_TEXT, 8'hFF); send(OP_TEXT, 8'h00);
    send(OP_END, 8'h00);
    drain();

    while (sent < ITEM_TARGET) begin
      idle_sender = ($urandom_range(0, 3) != 0);
      episodes++;
      pick = $urandom_range(0, 99);
      if (episodes == 8 || (pick < 3 && longs < 3)) begin
        longs++;
        search_episode(1'b1);
      end else if (pick < 85) begin
        search_episode(1'b0);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          send(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 19) == 0) drain();
    end

    drain();
    repeat (8) @(negedge clk);

    $display("Sent %0d commands over %0d episodes (%0d with full patterns).",
             sent, episodes, longs);
    $display("Checked %0d results: %0d found, %0d with overflow.", verdicts, hits, overflows);
    if (errors == 0 && pending == 0) begin
      $display("case_folding_substring_matcher_test: clean");
    end else begin
      $display("case_folding_substring_matcher_test: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/csm_pkg.sv
hw/rtl/csm_front.sv
hw/rtl/csm_back.sv
hw/rtl/case_folding_substring_matcher.sv
tb/csm_search_checker.sv
tb/case_folding_substring_matcher_test.sv
